FILE: sv/i2c_cr_pkg.sv
// Shared types, constants and byte functions of the I2C command responder.
package i2c_cr_pkg;

   localparam int RX_DEPTH = 13;
   localparam int RX_IDX_W = $clog2(RX_DEPTH);

   localparam logic [7:0] FILLER_BYTE = 8'h42;

   localparam logic [7:0] OP_STATUS   = 8'h0A;
   localparam logic [7:0] OP_SET_INTV = 8'h0B;
   localparam logic [7:0] OP_GET_INTV = 8'h0C;
   localparam logic [7:0] OP_SET_TIME = 8'h0D;
   localparam logic [7:0] OP_GET_TIME = 8'h0E;
   localparam logic [7:0] OP_NOP      = 8'h0F;
   localparam logic [7:0] OP_ADDR     = 8'h10;
   localparam logic [7:0] OP_DATA     = 8'h11;

   localparam logic [7:0] SUB_INIT   = 8'h00;
   localparam logic [7:0] SUB_XFER   = 8'h01;
   localparam logic [7:0] SUB_RESEND = 8'h02;
   localparam logic [7:0] SUB_STOP   = 8'h03;

   localparam int CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_DATA_START = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_DATA_END   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_CRC_EVERY  = 2'd2;

   typedef enum logic [3:0] {
      KIND_NONE, KIND_UNK, KIND_CRCE, KIND_ECHO, KIND_TIME, KIND_STATC, KIND_STATE,
      KIND_STATB, KIND_STATI, KIND_INTV, KIND_ADDR, KIND_BLOCK, KIND_NOMORE, KIND_STOP
   } answer_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_STEP, ST_FRAME, ST_BLK_CHECK, ST_BLK_MUL, ST_BLK_ADD, ST_BLK_FIT,
      ST_SCAN, ST_MODULO, ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic step;
      logic frame;
      logic blk_check;
      logic blk_mul;
      logic blk_add;
      logic blk_fit;
      logic scan;
      logic modulo;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic rsp_busy;
      logic step_frame;
      logic step_scan;
      logic frame_block;
      logic frame_scan;
      logic blk_none;
      logic scan_last;
      logic mod_skip;
      logic mod_last;
   } ctrl_status_type;

   function automatic logic [3:0] frame_length(logic [7:0] op);
      logic [3:0] len;
      unique case (op)
         OP_SET_TIME: len = 4'd9;
         OP_GET_TIME, OP_GET_INTV, OP_NOP, OP_ADDR: len = 4'd1;
         OP_STATUS: len = 4'd2;
         OP_SET_INTV: len = 4'd6;
         OP_DATA: len = 4'd12;
         default: len = 4'd0;
      endcase
      return len;
   endfunction

   // XOR of the counting payload 0, 1, 2 ... m-1 taken modulo 256
   function automatic logic [7:0] xor_count(logic [15:0] m);
      logic [7:0] k;
      logic [7:0] r;
      k = m[7:0] - 8'd1;
      case (k[1:0])
         2'd0: r = k;
         2'd1: r = 8'd1;
         2'd2: r = k + 8'd1;
         default: r = 8'd0;
      endcase
      if (m[7:0] == 8'd0) r = 8'd0;
      return r;
   endfunction

   // Byte at a position of an answer body, check byte excluded
   function automatic logic [7:0] body_byte(answer_kind_type kind, logic [16:0] pos,
                                            logic [63:0] stime, logic [2:0][31:0] intv,
                                            logic [3:0][31:0] flds);
      logic [16:0] i;
      logic [16:0] j;
      logic [16:0] e;
      logic [7:0]  r;
      i = pos - 17'd2;
      j = pos - 17'd1;
      e = i - 17'd12;
      r = 8'h00;
      case (kind) inside
         KIND_UNK:  r = (pos == 17'd0) ? 8'hFF : 8'h00;
         KIND_CRCE: r = (pos == 17'd0) ? 8'hFF : 8'h01;
         KIND_TIME: r = (pos == 17'd0) ? 8'h0E : 8'(stime >> {j[2:0], 3'b000});
         KIND_STATC, KIND_STATE, KIND_STATB, KIND_STATI: begin
            if (pos == 17'd0) r = 8'h0A;
            else if (pos == 17'd1) begin
               if (kind == KIND_STATI) r = 8'hFF;
               else if (kind == KIND_STATC) r = 8'h01;
               else if (kind == KIND_STATE) r = 8'h02;
               else r = 8'h03;
            end else if (kind == KIND_STATC) r = 8'h20 + {4'h0, i[3:0]};
            else if (kind == KIND_STATE) r = 8'h80 + {2'b00, i[5:0]};
            else if (i < 17'd12) r = 8'h20 + i[7:0];
            else r = 8'h80 + {2'b00, e[5:0]};
         end
         KIND_INTV: begin
            if (pos == 17'd0) r = 8'h0C;
            else if (j >= 17'd12) r = 8'h00;
            else r = 8'(intv[j[3:2]] >> {j[1:0], 3'b000});
         end
         KIND_ADDR: begin
            if (pos == 17'd0) r = 8'h10;
            else if (pos == 17'd1) r = 8'h00;
            else if (i >= 17'd8) r = 8'h00;
            else r = 8'(flds[i[3:2]] >> {i[1:0], 3'b000});
         end
         KIND_BLOCK: begin
            if (pos == 17'd0) r = 8'h11;
            else if (pos == 17'd1) r = 8'h01;
            else if (pos < 17'd16) r = 8'(flds[i[3:2]] >> {i[1:0], 3'b000});
            else r = pos[7:0] - 8'd16;
         end
         KIND_NOMORE: r = (pos == 17'd0) ? 8'h11 : 8'h16;
         KIND_STOP:   r = (pos == 17'd0) ? 8'h11 : 8'h03;
         default:     r = 8'h00;
      endcase
      return r;
   endfunction

endpackage

FILE: sv/i2c_cr_ctrl.sv
// Sequencing state machine of the I2C command responder.
module i2c_cr_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  i2c_cr_pkg::ctrl_status_type status,
   output i2c_cr_pkg::ctrl_cmd_type    cmd
);

   i2c_cr_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= i2c_cr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         i2c_cr_pkg::ST_IDLE:
            if (req_tvalid && !status.rsp_busy) state_in = i2c_cr_pkg::ST_STEP;
         i2c_cr_pkg::ST_STEP: begin
            if (status.step_frame) state_in = i2c_cr_pkg::ST_FRAME;
            else if (status.step_scan) state_in = i2c_cr_pkg::ST_SCAN;
            else state_in = i2c_cr_pkg::ST_IDLE;
         end
         i2c_cr_pkg::ST_FRAME: begin
            if (status.frame_block) state_in = i2c_cr_pkg::ST_BLK_CHECK;
            else if (status.frame_scan) state_in = i2c_cr_pkg::ST_SCAN;
            else state_in = i2c_cr_pkg::ST_IDLE;
         end
         i2c_cr_pkg::ST_BLK_CHECK:
            state_in = status.blk_none ? i2c_cr_pkg::ST_SCAN : i2c_cr_pkg::ST_BLK_MUL;
         i2c_cr_pkg::ST_BLK_MUL: state_in = i2c_cr_pkg::ST_BLK_ADD;
         i2c_cr_pkg::ST_BLK_ADD: state_in = i2c_cr_pkg::ST_BLK_FIT;
         i2c_cr_pkg::ST_BLK_FIT: state_in = i2c_cr_pkg::ST_SCAN;
         i2c_cr_pkg::ST_SCAN:
            if (status.scan_last)
               state_in = status.mod_skip ? i2c_cr_pkg::ST_FINISH : i2c_cr_pkg::ST_MODULO;
         i2c_cr_pkg::ST_MODULO:
            if (status.mod_last) state_in = i2c_cr_pkg::ST_FINISH;
         i2c_cr_pkg::ST_FINISH: state_in = i2c_cr_pkg::ST_IDLE;
         default: state_in = i2c_cr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         i2c_cr_pkg::ST_IDLE: begin
            req_tready = !status.rsp_busy;
            cmd.capture = req_tvalid && !status.rsp_busy;
         end
         i2c_cr_pkg::ST_STEP:      cmd.step = 1'b1;
         i2c_cr_pkg::ST_FRAME:     cmd.frame = 1'b1;
         i2c_cr_pkg::ST_BLK_CHECK: cmd.blk_check = 1'b1;
         i2c_cr_pkg::ST_BLK_MUL:   cmd.blk_mul = 1'b1;
         i2c_cr_pkg::ST_BLK_ADD:   cmd.blk_add = 1'b1;
         i2c_cr_pkg::ST_BLK_FIT:   cmd.blk_fit = 1'b1;
         i2c_cr_pkg::ST_SCAN:      cmd.scan = 1'b1;
         i2c_cr_pkg::ST_MODULO:    cmd.modulo = 1'b1;
         i2c_cr_pkg::ST_FINISH:    cmd.finish = 1'b1;
         default: cmd = '0;
      endcase
   end

endmodule

FILE: sv/i2c_cr_dpath.sv
// Receive buffer, answer state, block arithmetic and checksum datapath.
module i2c_cr_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  i2c_cr_pkg::ctrl_cmd_type             cmd,
   output i2c_cr_pkg::ctrl_status_type          status,
   input  logic [1:0]                           req_tuser,
   input  logic [7:0]                           req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [7:0]                           rsp_tdata,
   output logic [0:0]                           rsp_tuser,
   input  logic                                 csr_we,
   input  logic [i2c_cr_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [31:0]                          csr_wdata
);

   localparam int RXD = i2c_cr_pkg::RX_DEPTH;
   localparam int RXW = i2c_cr_pkg::RX_IDX_W;

   // configuration
   logic [31:0] data_start_ff, data_start_in;
   logic [31:0] data_end_ff, data_end_in;
   logic [7:0]  crc_every_ff, crc_every_in;

   // captured item
   logic       func_ff, func_in;
   logic       first_ff, first_in;
   logic [7:0] byte_ff, byte_in;

   // receive framing
   logic [7:0]  rx_ff [RXD];
   logic [7:0]  rx_in [RXD];
   logic [7:0]  rx_check_ff, rx_check_in;
   logic [3:0]  rx_count_ff, rx_count_in;
   logic [3:0]  exp_len_ff, exp_len_in;

   // architectural state
   logic [63:0]       sync_time_ff, sync_time_in;
   logic [2:0][31:0]  intv_ff, intv_in;
   logic [31:0]       blocks_left_ff, blocks_left_in;
   logic [31:0]       blocks_asked_ff, blocks_asked_in;
   logic [15:0]       block_bytes_ff, block_bytes_in;
   logic [15:0]       answer_count_ff, answer_count_in;
   i2c_cr_pkg::answer_kind_type kind_ff, kind_in;
   logic [16:0]       pos_ff, pos_in;
   logic [16:0]       left_ff, left_in;
   logic [7:0]        check_ff, check_in;
   logic [3:0][31:0]  flds_ff, flds_in;

   // block arithmetic and checksum work registers
   logic [31:0] nr_ff, nr_in;
   logic [31:0] prod_ff, prod_in;
   logic [31:0] start_ff, start_in;
   logic [5:0]  scan_pos_ff, scan_pos_in;
   logic [5:0]  scan_end_ff, scan_end_in;
   logic [7:0]  scan_check_ff, scan_check_in;
   logic        counted_ff, counted_in;
   logic [7:0]  mod_rem_ff, mod_rem_in;
   logic [3:0]  mod_cnt_ff, mod_cnt_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff, rsp_data_in;
   logic       rsp_user_ff, rsp_user_in;

   // combinational helpers
   logic [RXW-1:0] idx;
   logic [7:0]     rx0_now;
   logic [3:0]     new_exp;
   logic           frame_end;
   logic           check_ok;
   logic [3:0]     first_len;
   logic [16:0]    body_pos;
   logic [7:0]     body_b;
   logic [7:0]     echo_b;
   logic [7:0]     op;
   logic [7:0]     sub;

   i2c_cr_pkg::answer_kind_type fr_kind;
   logic [16:0] fr_len;
   logic        fr_counted;
   logic        fr_start;

   i2c_cr_pkg::answer_kind_type ans_kind;
   logic [16:0] ans_len;
   logic        ans_counted;
   logic        ans_start;

   logic [31:0] end_raw;
   logic [31:0] n_clip;
   logic [8:0]  mod_try;

   always_comb begin
      idx = (rx_count_ff >= 4'(RXD - 1)) ? RXW'(RXD - 1) : RXW'(rx_count_ff);
      rx0_now = (idx == '0) ? byte_ff : rx_ff[0];
      new_exp = (rx0_now == i2c_cr_pkg::OP_DATA && idx == RXW'(1) && byte_ff != 8'h00)
                ? 4'd2 : exp_len_ff;
      frame_end = (new_exp != 4'd0) && (4'(idx) >= new_exp);
      check_ok = (rx_check_ff == byte_ff);
      first_len = i2c_cr_pkg::frame_length(byte_ff);
      body_pos = cmd.scan ? {11'd0, scan_pos_ff} : pos_ff;
      body_b = i2c_cr_pkg::body_byte(kind_ff, body_pos, sync_time_ff, intv_ff, flds_ff);
      echo_b = (pos_ff < 17'(RXD)) ? rx_ff[pos_ff[RXW-1:0]] : 8'h00;
      op = rx_ff[0];
      sub = rx_ff[1];
      end_raw = start_ff + {16'd0, block_bytes_ff} - 32'd1;
      n_clip = data_end_ff - start_ff + 32'd1;
      mod_try = {mod_rem_ff, answer_count_ff[mod_cnt_ff]};
   end

   // decode of a completed frame
   always_comb begin
      fr_kind = i2c_cr_pkg::KIND_NONE;
      fr_len = 17'd0;
      fr_counted = 1'b0;
      fr_start = 1'b1;
      unique case (op)
         i2c_cr_pkg::OP_SET_TIME: begin
            fr_kind = i2c_cr_pkg::KIND_ECHO;
            fr_len = 17'd10;
         end
         i2c_cr_pkg::OP_GET_TIME: begin
            fr_kind = i2c_cr_pkg::KIND_TIME;
            fr_len = 17'd10;
         end
         i2c_cr_pkg::OP_STATUS: begin
            fr_counted = 1'b1;
            if (sub == 8'd1) begin
               fr_kind = i2c_cr_pkg::KIND_STATC;
               fr_len = 17'd15;
            end else if (sub == 8'd2) begin
               fr_kind = i2c_cr_pkg::KIND_STATE;
               fr_len = 17'd33;
            end else if (sub == 8'd3) begin
               fr_kind = i2c_cr_pkg::KIND_STATB;
               fr_len = 17'd45;
            end else begin
               fr_kind = i2c_cr_pkg::KIND_STATI;
               fr_len = 17'd3;
            end
         end
         i2c_cr_pkg::OP_GET_INTV: begin
            fr_kind = i2c_cr_pkg::KIND_INTV;
            fr_len = 17'd14;
            fr_counted = 1'b1;
         end
         i2c_cr_pkg::OP_SET_INTV: begin
            fr_kind = i2c_cr_pkg::KIND_ECHO;
            fr_len = 17'd7;
         end
         i2c_cr_pkg::OP_ADDR: begin
            fr_kind = i2c_cr_pkg::KIND_ADDR;
            fr_len = 17'd11;
            fr_counted = 1'b1;
         end
         i2c_cr_pkg::OP_DATA: begin
            if (sub == i2c_cr_pkg::SUB_INIT) begin
               fr_kind = i2c_cr_pkg::KIND_ECHO;
               fr_len = 17'd13;
            end else if (sub == i2c_cr_pkg::SUB_XFER || sub == i2c_cr_pkg::SUB_RESEND) begin
               fr_start = 1'b0;
            end else if (sub == i2c_cr_pkg::SUB_STOP) begin
               fr_kind = i2c_cr_pkg::KIND_STOP;
               fr_len = 17'd3;
               fr_counted = 1'b1;
            end
         end
         default: fr_kind = i2c_cr_pkg::KIND_NONE;
      endcase
   end

   always_comb begin
      status.rsp_busy = rsp_valid_ff;
      status.step_frame = !func_ff && !first_ff && frame_end && check_ok;
      status.step_scan = !func_ff && (first_ff ? (first_len == 4'd0) : (frame_end && !check_ok));
      status.frame_block = !fr_start;
      status.frame_scan = fr_start && fr_kind != i2c_cr_pkg::KIND_ECHO
                          && fr_kind != i2c_cr_pkg::KIND_NONE;
      status.blk_none = (blocks_left_ff == 32'd0);
      status.scan_last = (scan_pos_ff == scan_end_ff);
      status.mod_skip = !counted_ff || crc_every_ff == 8'd0;
      status.mod_last = (mod_cnt_ff == 4'd0);
   end

   always_comb begin
      data_start_in = data_start_ff;
      data_end_in = data_end_ff;
      crc_every_in = crc_every_ff;
      func_in = func_ff;
      first_in = first_ff;
      byte_in = byte_ff;
      rx_in = rx_ff;
      rx_check_in = rx_check_ff;
      rx_count_in = rx_count_ff;
      exp_len_in = exp_len_ff;
      sync_time_in = sync_time_ff;
      intv_in = intv_ff;
      blocks_left_in = blocks_left_ff;
      blocks_asked_in = blocks_asked_ff;
      block_bytes_in = block_bytes_ff;
      answer_count_in = answer_count_ff;
      kind_in = kind_ff;
      pos_in = pos_ff;
      left_in = left_ff;
      check_in = check_ff;
      flds_in = flds_ff;
      nr_in = nr_ff;
      prod_in = prod_ff;
      start_in = start_ff;
      scan_pos_in = scan_pos_ff;
      scan_end_in = scan_end_ff;
      scan_check_in = scan_check_ff;
      counted_in = counted_ff;
      mod_rem_in = mod_rem_ff;
      mod_cnt_in = mod_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      ans_start = 1'b0;
      ans_kind = i2c_cr_pkg::KIND_NONE;
      ans_len = 17'd0;
      ans_counted = 1'b0;

      if (csr_we) begin
         unique case (csr_addr)
            i2c_cr_pkg::CSR_DATA_START: data_start_in = csr_wdata;
            i2c_cr_pkg::CSR_DATA_END:   data_end_in = csr_wdata;
            i2c_cr_pkg::CSR_CRC_EVERY:  crc_every_in = csr_wdata[7:0];
            default: crc_every_in = crc_every_ff;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      if (cmd.capture) begin
         func_in = req_tuser[0];
         first_in = req_tuser[1];
         byte_in = req_tdata;
      end

      if (cmd.step) begin
         if (func_ff) begin
            rsp_valid_in = 1'b1;
            if (left_ff != 17'd0) begin
               rsp_user_in = 1'b1;
               if (kind_ff == i2c_cr_pkg::KIND_ECHO) rsp_data_in = echo_b;
               else if (left_ff == 17'd1) rsp_data_in = check_ff;
               else rsp_data_in = body_b;
               pos_in = pos_ff + 17'd1;
               left_in = left_ff - 17'd1;
               if (left_ff == 17'd1) kind_in = i2c_cr_pkg::KIND_NONE;
            end else begin
               rsp_user_in = 1'b0;
               rsp_data_in = i2c_cr_pkg::FILLER_BYTE;
            end
         end else if (first_ff) begin
            rx_in[0] = byte_ff;
            rx_count_in = 4'd1;
            exp_len_in = first_len;
            if (first_len == 4'd0) begin
               ans_start = 1'b1;
               ans_kind = i2c_cr_pkg::KIND_UNK;
               ans_len = 17'd3;
            end else begin
               rx_check_in = byte_ff;
            end
         end else begin
            rx_in[idx] = byte_ff;
            exp_len_in = new_exp;
            if (frame_end) begin
               if (!check_ok) begin
                  ans_start = 1'b1;
                  ans_kind = i2c_cr_pkg::KIND_CRCE;
                  ans_len = 17'd3;
               end
            end else begin
               rx_check_in = rx_check_ff ^ byte_ff;
               if (rx_count_ff < 4'(RXD - 1)) rx_count_in = rx_count_ff + 4'd1;
            end
         end
      end

      if (cmd.frame) begin
         ans_start = fr_start;
         ans_kind = fr_kind;
         ans_len = fr_len;
         ans_counted = fr_counted;
         if (op == i2c_cr_pkg::OP_SET_TIME) begin
            sync_time_in = {rx_ff[8], rx_ff[7], rx_ff[6], rx_ff[5],
                            rx_ff[4], rx_ff[3], rx_ff[2], rx_ff[1]};
         end
         if (op == i2c_cr_pkg::OP_SET_INTV && sub >= 8'd1 && sub <= 8'd3) begin
            intv_in[2'(sub - 8'd1)] = {rx_ff[5], rx_ff[4], rx_ff[3], rx_ff[2]};
         end
         if (op == i2c_cr_pkg::OP_ADDR) begin
            flds_in[0] = data_start_ff;
            flds_in[1] = data_end_ff;
         end
         if (op == i2c_cr_pkg::OP_DATA && sub == i2c_cr_pkg::SUB_INIT) begin
            blocks_left_in = {rx_ff[11], rx_ff[10], rx_ff[9], rx_ff[8]};
            blocks_asked_in = {rx_ff[11], rx_ff[10], rx_ff[9], rx_ff[8]};
            block_bytes_in = {rx_ff[3], rx_ff[2]};
         end
         if (op == i2c_cr_pkg::OP_DATA && sub == i2c_cr_pkg::SUB_RESEND) begin
            blocks_left_in = blocks_left_ff + 32'd1;
         end
      end

      if (cmd.blk_check) begin
         if (blocks_left_ff == 32'd0) begin
            ans_start = 1'b1;
            ans_kind = i2c_cr_pkg::KIND_NOMORE;
            ans_len = 17'd3;
            ans_counted = 1'b1;
         end
         nr_in = blocks_asked_ff - blocks_left_ff;
      end

      if (cmd.blk_mul) prod_in = 32'(nr_ff * block_bytes_ff);

      if (cmd.blk_add) start_in = prod_ff + data_start_ff;

      if (cmd.blk_fit) begin
         ans_start = 1'b1;
         ans_counted = 1'b1;
         if (start_ff > data_end_ff) begin
            ans_kind = i2c_cr_pkg::KIND_NOMORE;
            ans_len = 17'd3;
         end else begin
            ans_kind = i2c_cr_pkg::KIND_BLOCK;
            blocks_left_in = blocks_left_ff - 32'd1;
            flds_in[0] = start_ff;
            flds_in[2] = nr_ff;
            if (end_raw > data_end_ff) begin
               flds_in[1] = data_end_ff;
               flds_in[3] = {16'd0, n_clip[15:0]};
               ans_len = 17'(n_clip[15:0]) + 17'd17;
            end else begin
               flds_in[1] = end_raw;
               flds_in[3] = {16'd0, block_bytes_ff};
               ans_len = 17'(block_bytes_ff) + 17'd17;
            end
         end
      end

      // open a new answer, replacing any pending one
      if (ans_start) begin
         kind_in = ans_kind;
         pos_in = 17'd0;
         left_in = ans_len;
         check_in = 8'h00;
         scan_pos_in = 6'd0;
         scan_end_in = (ans_kind == i2c_cr_pkg::KIND_BLOCK) ? 6'd15 : 6'(ans_len - 17'd2);
         scan_check_in = 8'h00;
         counted_in = ans_counted;
         mod_rem_in = 8'h00;
         mod_cnt_in = 4'd15;
         if (ans_counted) answer_count_in = answer_count_ff + 16'd1;
      end

      // one header byte per cycle into the check
      if (cmd.scan) begin
         scan_check_in = scan_check_ff ^ body_b;
         if (status.scan_last && kind_ff == i2c_cr_pkg::KIND_BLOCK)
            scan_check_in = scan_check_ff ^ body_b ^ i2c_cr_pkg::xor_count(flds_ff[3][15:0]);
         scan_pos_in = scan_pos_ff + 6'd1;
      end

      // restoring remainder of the answer count, one bit per cycle
      if (cmd.modulo) begin
         if (mod_try >= {1'b0, crc_every_ff}) mod_rem_in = 8'(mod_try - {1'b0, crc_every_ff});
         else mod_rem_in = mod_try[7:0];
         mod_cnt_in = mod_cnt_ff - 4'd1;
      end

      if (cmd.finish) begin
         check_in = scan_check_ff;
         if (counted_ff && crc_every_ff != 8'd0 && mod_rem_ff == 8'd0)
            check_in = scan_check_ff + 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_start_ff <= 32'd4000;
         data_end_ff <= 32'd4500;
         crc_every_ff <= 8'd0;
         rx_check_ff <= 8'd0;
         rx_count_ff <= 4'd0;
         exp_len_ff <= 4'd0;
         sync_time_ff <= 64'd0;
         intv_ff <= {32'd10042, 32'd1000, 32'd100};
         blocks_left_ff <= 32'd0;
         blocks_asked_ff <= 32'd0;
         block_bytes_ff <= 16'd0;
         answer_count_ff <= 16'd0;
         kind_ff <= i2c_cr_pkg::KIND_NONE;
         pos_ff <= 17'd0;
         left_ff <= 17'd0;
         check_ff <= 8'd0;
         flds_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         data_start_ff <= data_start_in;
         data_end_ff <= data_end_in;
         crc_every_ff <= crc_every_in;
         rx_check_ff <= rx_check_in;
         rx_count_ff <= rx_count_in;
         exp_len_ff <= exp_len_in;
         sync_time_ff <= sync_time_in;
         intv_ff <= intv_in;
         blocks_left_ff <= blocks_left_in;
         blocks_asked_ff <= blocks_asked_in;
         block_bytes_ff <= block_bytes_in;
         answer_count_ff <= answer_count_in;
         kind_ff <= kind_in;
         pos_ff <= pos_in;
         left_ff <= left_in;
         check_ff <= check_in;
         flds_ff <= flds_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in;
      first_ff <= first_in;
      byte_ff <= byte_in;
      rx_ff <= rx_in;
      nr_ff <= nr_in;
      prod_ff <= prod_in;
      start_ff <= start_in;
      scan_pos_ff <= scan_pos_in;
      scan_end_ff <= scan_end_in;
      scan_check_ff <= scan_check_in;
      counted_ff <= counted_in;
      mod_rem_ff <= mod_rem_in;
      mod_cnt_ff <= mod_cnt_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

endmodule

FILE: sv/i2c_command_responder_core.sv
// Top level of the I2C command responder: controller plus datapath.
// A read request is captured on acceptance and its byte is registered in the step state; the next
// transfer is taken only after the byte leaves. A written byte is taken in the step state.
// A byte that closes a frame goes on through more steps: one header byte per cycle into the check
// (44 at most), 16 remainder steps for checksum corruption, and four more for a data block.
// Synchronous reset, active high, restores register defaults and drops any pending answer.
module i2c_command_responder_core (
   input  logic                               clock,
   input  logic                               reset,
   // written bytes and read requests
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,  // [7:0] wr_data
   input  logic [1:0]                         req_tuser,  // [0] func, [1] first_byte
   // bytes returned for read requests
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [7:0]                         rsp_tdata,  // [7:0] read_data
   output logic [0:0]                         rsp_tuser,  // [0] from_answer
   // register writes
   input  logic                               csr_we,
   input  logic [i2c_cr_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [31:0]                        csr_wdata
);

   // command and status between the sequencer and the datapath
   i2c_cr_pkg::ctrl_cmd_type    cmd;
   i2c_cr_pkg::ctrl_status_type status;

   // sequencer: hold the input while a byte is worked on or a result transfer is still pending
   i2c_cr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // datapath: frame bytes, build answers, advance the read pointer
   i2c_cr_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

endmodule

FILE: tb/tb_i2c_command_responder_core.sv
// Self-checking testbench of the I2C command responder core.
`timescale 1ns / 1ps

module tb_i2c_command_responder_core;

   localparam logic [7:0] UNKNOWN_OP  = 8'hFF;
   localparam int         WATCHDOG    = 20000;
   localparam int         DRAIN_WAIT  = 100;   // room for the longest frame close
   localparam int         ITEM_TARGET = 1600;
   localparam int         QUIET_FROM  = 1400;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_we;
   logic [i2c_cr_pkg::CSR_ADDR_W-1:0] csr_addr;
   logic [31:0] csr_wdata;

   i2c_command_responder_core u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   // period 20 ns
   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // ------------------------------------------------------------------
   // Responder state as the testbench sees it
   // ------------------------------------------------------------------
   logic [31:0] cfg_start, cfg_end;
   logic [7:0]  cfg_every;

   logic [7:0]  rx_frame [i2c_cr_pkg::RX_DEPTH];
   logic [7:0]  rx_xor;
   int unsigned rx_pos, frame_len;
   logic [63:0] clock_time;
   logic [31:0] intervals [3];
   logic [31:0] blk_left, blk_asked;
   logic [15:0] blk_bytes, answers_built;
   i2c_cr_pkg::answer_kind_type pend_kind;
   int unsigned pend_pos, pend_left;
   logic [7:0]  pend_check;
   logic [31:0] snap [4];   // start, end, block number, byte count

   typedef struct packed {
      logic [7:0] data;
      logic       from_answer;
   } read_byte_type;

   read_byte_type bytes_due [$];
   int            fail_count;
   int            items_sent;
   int            idle_cycles;
   bit            quiet;

   // fields that the current transfer carries besides the bus
   bit            cur_typed;
   read_byte_type cur_typed_val;

   function automatic logic [7:0] rx_at(int unsigned i);
      return (i < i2c_cr_pkg::RX_DEPTH) ? rx_frame[i] : 8'h00;
   endfunction

   function automatic logic [31:0] rx_word(int unsigned at);
      return {rx_at(at + 3), rx_at(at + 2), rx_at(at + 1), rx_at(at)};
   endfunction

   function automatic logic [7:0] op_frame_len(logic [7:0] op);
      case (op)
         i2c_cr_pkg::OP_SET_TIME: return 8'd9;
         i2c_cr_pkg::OP_GET_TIME, i2c_cr_pkg::OP_GET_INTV, i2c_cr_pkg::OP_NOP,
         i2c_cr_pkg::OP_ADDR: return 8'd1;
         i2c_cr_pkg::OP_STATUS: return 8'd2;
         i2c_cr_pkg::OP_SET_INTV: return 8'd6;
         i2c_cr_pkg::OP_DATA: return 8'd12;
         default: return 8'd0;
      endcase
   endfunction

   function automatic logic [7:0] pend_body(int unsigned p);
      int unsigned i;
      case (pend_kind)
         i2c_cr_pkg::KIND_UNK:  return (p == 0) ? 8'hFF : 8'h00;
         i2c_cr_pkg::KIND_CRCE: return (p == 0) ? 8'hFF : 8'h01;
         i2c_cr_pkg::KIND_TIME: return (p == 0) ? 8'h0E : clock_time[8 * ((p - 1) % 8) +: 8];
         i2c_cr_pkg::KIND_STATC, i2c_cr_pkg::KIND_STATE, i2c_cr_pkg::KIND_STATB,
         i2c_cr_pkg::KIND_STATI: begin
            if (p == 0) return 8'h0A;
            if (p == 1) begin
               if (pend_kind == i2c_cr_pkg::KIND_STATI) return 8'hFF;
               return 8'(int'(pend_kind) - int'(i2c_cr_pkg::KIND_STATC) + 1);
            end
            i = p - 2;
            if (pend_kind == i2c_cr_pkg::KIND_STATC) return 8'(8'h20 + (i & 15));
            if (pend_kind == i2c_cr_pkg::KIND_STATE) return 8'(8'h80 + (i & 63));
            if (i < 12) return 8'(8'h20 + i);
            return 8'(8'h80 + ((i - 12) & 63));
         end
         i2c_cr_pkg::KIND_INTV: begin
            if (p == 0) return 8'h0C;
            i = p - 1;
            if (i >= 12) return 8'h00;
            return intervals[i / 4][8 * (i % 4) +: 8];
         end
         i2c_cr_pkg::KIND_ADDR: begin
            if (p == 0) return 8'h10;
            if (p == 1) return 8'h00;
            i = p - 2;
            if (i >= 8) return 8'h00;
            return snap[i / 4][8 * (i % 4) +: 8];
         end
         i2c_cr_pkg::KIND_BLOCK: begin
            if (p == 0) return 8'h11;
            if (p == 1) return 8'h01;
            i = p - 2;
            if (p < 16) return snap[i / 4][8 * (i % 4) +: 8];
            return 8'(p - 16);
         end
         i2c_cr_pkg::KIND_NOMORE: return (p == 0) ? 8'h11 : 8'h16;
         i2c_cr_pkg::KIND_STOP:   return (p == 0) ? 8'h11 : 8'h03;
         default:                 return 8'h00;
      endcase
   endfunction

   // XOR over the counting payload; 256 bytes of it cancel out
   function automatic logic [7:0] payload_xor(logic [31:0] n);
      logic [7:0] r;
      r = 8'h00;
      for (int j = 0; j < int'(n[7:0]); j++) r ^= 8'(j);
      return r;
   endfunction

   function automatic void open_answer(i2c_cr_pkg::answer_kind_type kind, int unsigned len,
                                       bit counted);
      logic [7:0]  c;
      int unsigned hdr;
      c = 8'h00;
      pend_kind  = kind;
      pend_pos   = 0;
      pend_left  = len;
      pend_check = 8'h00;
      if (kind == i2c_cr_pkg::KIND_ECHO || kind == i2c_cr_pkg::KIND_NONE) return;
      hdr = (kind == i2c_cr_pkg::KIND_BLOCK) ? 16 : len - 1;
      for (int unsigned p = 0; p < hdr; p++) c ^= pend_body(p);
      if (kind == i2c_cr_pkg::KIND_BLOCK) c ^= payload_xor(snap[3]);
      if (counted) begin
         answers_built = answers_built + 16'd1;
         if (cfg_every != 0 && (int'(answers_built) % int'(cfg_every)) == 0) c = c + 8'd1;
      end
      pend_check = c;
   endfunction

   function automatic void serve_block();
      logic [31:0] nr, first, last, n;
      if (blk_left == 0) begin
         open_answer(i2c_cr_pkg::KIND_NOMORE, 3, 1'b1);
         return;
      end
      nr    = blk_asked - blk_left;
      first = nr * {16'h0, blk_bytes} + cfg_start;
      if (first > cfg_end) begin
         open_answer(i2c_cr_pkg::KIND_NOMORE, 3, 1'b1);
         return;
      end
      last = first + {16'h0, blk_bytes} - 32'd1;
      n    = {16'h0, blk_bytes};
      if (last > cfg_end) begin
         last = cfg_end;
         n    = (cfg_end - first + 32'd1) & 32'hFFFF;
      end
      blk_left = blk_left - 32'd1;
      snap[0] = first;
      snap[1] = last;
      snap[2] = nr;
      snap[3] = n;
      open_answer(i2c_cr_pkg::KIND_BLOCK, 17 + n, 1'b1);
   endfunction

   function automatic void take_frame();
      logic [7:0] t;
      t = rx_at(1);
      case (rx_at(0))
         i2c_cr_pkg::OP_SET_TIME: begin
            open_answer(i2c_cr_pkg::KIND_ECHO, 10, 1'b0);
            for (int k = 0; k < 8; k++) clock_time[8 * k +: 8] = rx_at(1 + k);
         end
         i2c_cr_pkg::OP_GET_TIME: open_answer(i2c_cr_pkg::KIND_TIME, 10, 1'b0);
         i2c_cr_pkg::OP_STATUS: begin
            if (t == 8'd1) open_answer(i2c_cr_pkg::KIND_STATC, 15, 1'b1);
            else if (t == 8'd2) open_answer(i2c_cr_pkg::KIND_STATE, 33, 1'b1);
            else if (t == 8'd3) open_answer(i2c_cr_pkg::KIND_STATB, 45, 1'b1);
            else open_answer(i2c_cr_pkg::KIND_STATI, 3, 1'b1);
         end
         i2c_cr_pkg::OP_GET_INTV: open_answer(i2c_cr_pkg::KIND_INTV, 14, 1'b1);
         i2c_cr_pkg::OP_SET_INTV: begin
            open_answer(i2c_cr_pkg::KIND_ECHO, 7, 1'b0);
            // an interval type outside 1..3 is dropped, echo still goes out
            if (t >= 8'd1 && t <= 8'd3) intervals[t - 1] = rx_word(2);
         end
         i2c_cr_pkg::OP_ADDR: begin
            snap[0] = cfg_start;
            snap[1] = cfg_end;
            open_answer(i2c_cr_pkg::KIND_ADDR, 11, 1'b1);
         end
         i2c_cr_pkg::OP_DATA: begin
            if (t == i2c_cr_pkg::SUB_INIT) begin
               open_answer(i2c_cr_pkg::KIND_ECHO, 13, 1'b0);
               blk_left  = rx_word(8);
               blk_asked = blk_left;
               blk_bytes = {rx_at(3), rx_at(2)};
            end else if (t == i2c_cr_pkg::SUB_XFER) begin
               serve_block();
            end else if (t == i2c_cr_pkg::SUB_RESEND) begin
               blk_left = blk_left + 32'd1;
               serve_block();
            end else if (t == i2c_cr_pkg::SUB_STOP) begin
               open_answer(i2c_cr_pkg::KIND_STOP, 3, 1'b1);
            end else begin
               open_answer(i2c_cr_pkg::KIND_NONE, 0, 1'b0);
            end
         end
         default: open_answer(i2c_cr_pkg::KIND_NONE, 0, 1'b0);
      endcase
   endfunction

   // Advance the responder by one accepted transfer; returns 1 when a byte is due.
   function automatic bit responder_step(bit rd, bit first, logic [7:0] b,
                                         output read_byte_type due);
      int unsigned idx;
      due = '0;
      if (rd) begin
         if (pend_left > 0) begin
            if (pend_kind == i2c_cr_pkg::KIND_ECHO) due.data = rx_at(pend_pos);
            else if (pend_left == 1) due.data = pend_check;
            else due.data = pend_body(pend_pos);
            due.from_answer = 1'b1;
            pend_pos++;
            pend_left--;
            if (pend_left == 0) pend_kind = i2c_cr_pkg::KIND_NONE;
         end else begin
            due.data = i2c_cr_pkg::FILLER_BYTE;
            due.from_answer = 1'b0;
         end
         return 1'b1;
      end
      if (first) begin
         rx_frame[0] = b;
         rx_pos      = 1;
         frame_len   = op_frame_len(b);
         if (frame_len == 0) open_answer(i2c_cr_pkg::KIND_UNK, 3, 1'b0);
         else rx_xor = b;
         return 1'b0;
      end
      idx = (rx_pos >= i2c_cr_pkg::RX_DEPTH) ? i2c_cr_pkg::RX_DEPTH - 1 : rx_pos;
      rx_frame[idx] = b;
      // a data subcommand other than init cuts the frame to two bytes
      if (rx_frame[0] == i2c_cr_pkg::OP_DATA && idx == 1 && b != 8'h00) frame_len = 2;
      if (frame_len > 0 && idx >= frame_len) begin
         if (rx_xor == b) take_frame();
         else open_answer(i2c_cr_pkg::KIND_CRCE, 3, 1'b0);
      end else begin
         rx_xor ^= b;
         if (rx_pos < i2c_cr_pkg::RX_DEPTH - 1) rx_pos++;
      end
      return 1'b0;
   endfunction

   // ------------------------------------------------------------------
   // Monitor: check returned bytes, predict on every request transfer
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      read_byte_type got, want, due;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.data        = rsp_tdata;
            got.from_answer = rsp_tuser[0];
            if (bytes_due.size() == 0) begin
               $error("unexpected response transfer: read_data %02h from_answer %0b",
                      got.data, got.from_answer);
               fail_count++;
            end else begin
               want = bytes_due.pop_front();
               if (got.data !== want.data) begin
                  $error("read_data: expected %02h, actual %02h", want.data, got.data);
                  fail_count++;
               end
               if (got.from_answer !== want.from_answer) begin
                  $error("from_answer: expected %0b, actual %0b",
                         want.from_answer, got.from_answer);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (responder_step(req_tuser[0], req_tuser[1], req_tdata, due))
               bytes_due.push_back(cur_typed ? cur_typed_val : due);
         end
         // watchdog on cycles with no transfer on either side
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG) begin
            $display("** i2c_command_responder_core: FAILED **");
            $finish;
         end
      end
   end

   // Receiver: random stall bursts, none in the quiet tail
   always begin
      @(negedge clock);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         rsp_tready = 1'b0;
         repeat ($urandom_range(0, 16)) @(negedge clock);
      end else begin
         rsp_tready = 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // Sender
   // ------------------------------------------------------------------
   task automatic send_item(bit rd, bit first, logic [7:0] b,
                            bit typed = 1'b0, read_byte_type typed_val = '0);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat ($urandom_range(0, 16)) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid    = 1'b1;
      req_tuser     = {first, rd};
      req_tdata     = b;
      cur_typed     = typed;
      cur_typed_val = typed_val;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (items_sent >= QUIET_FROM) quiet = 1'b1;
   endtask

   // Hold off until every byte due has come, then let a frame close finish.
   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      cur_typed  = 1'b0;
      while (bytes_due.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic csr_write(logic [i2c_cr_pkg::CSR_ADDR_W-1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_addr  = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we    = 1'b0;
      case (idx)
         i2c_cr_pkg::CSR_DATA_START: cfg_start = val;
         i2c_cr_pkg::CSR_DATA_END:   cfg_end   = val;
         i2c_cr_pkg::CSR_CRC_EVERY:  cfg_every = val[7:0];
         default: ;
      endcase
   endtask

   task automatic set_area(int phase);
      logic [31:0] s, e;
      logic [7:0]  every;
      case (phase % 4)
         0: begin s = 32'd0;          e = 32'hFFFF_FFFF; every = 8'd255; end
         1: begin s = 32'hFFFF_FF00;  e = 32'hFFFF_FFFF; every = 8'd1;   end
         2: begin s = $urandom;       e = 32'd0;         every = 8'd0;   end
         default: begin
            s = $urandom;
            e = s + $urandom_range(0, 300);
            every = 8'($urandom_range(2, 7));
         end
      endcase
      if (phase % 4 == 2) e = s + $urandom_range(0, 120);
      csr_write(i2c_cr_pkg::CSR_DATA_START, s);
      csr_write(i2c_cr_pkg::CSR_DATA_END, e);
      csr_write(i2c_cr_pkg::CSR_CRC_EVERY, {24'h0, every});
   endtask

   // One command frame with random content, mostly well formed, then some reads
   task automatic send_command();
      logic [7:0] fr [$];
      logic [7:0] op, chk, sub;
      int         sel, n_reads;
      sel = $urandom_range(0, 12);
      case (sel)
         0: begin
            fr.push_back(i2c_cr_pkg::OP_SET_TIME);
            repeat (8) fr.push_back(8'($urandom));
         end
         1: fr.push_back(i2c_cr_pkg::OP_GET_TIME);
         2: begin
            fr.push_back(i2c_cr_pkg::OP_STATUS);
            fr.push_back(($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4)));
         end
         3: fr.push_back(i2c_cr_pkg::OP_GET_INTV);
         4: begin
            fr.push_back(i2c_cr_pkg::OP_SET_INTV);
            fr.push_back(($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4)));
            repeat (4) fr.push_back(8'($urandom));
         end
         5: fr.push_back(i2c_cr_pkg::OP_NOP);
         6: fr.push_back(i2c_cr_pkg::OP_ADDR);
         7, 8: begin
            // block setup: mostly small blocks, few of them
            fr.push_back(i2c_cr_pkg::OP_DATA);
            fr.push_back(i2c_cr_pkg::SUB_INIT);
            case ($urandom_range(0, 9))
               0: begin fr.push_back(8'h00); fr.push_back(8'h00); end
               1: begin fr.push_back(8'($urandom)); fr.push_back(8'($urandom)); end
               default: begin fr.push_back(8'($urandom_range(1, 40))); fr.push_back(8'h00); end
            endcase
            repeat (4) fr.push_back(8'($urandom));
            fr.push_back(8'($urandom_range(0, 6)));
            if ($urandom_range(0, 9) == 0) begin
               repeat (3) fr.push_back(8'($urandom));
            end else begin
               repeat (3) fr.push_back(8'h00);
            end
         end
         9, 10: begin
            fr.push_back(i2c_cr_pkg::OP_DATA);
            sub = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                  : (($urandom_range(0, 3) == 0) ? i2c_cr_pkg::SUB_RESEND
                                                 : i2c_cr_pkg::SUB_XFER);
            if ($urandom_range(0, 7) == 0) sub = i2c_cr_pkg::SUB_STOP;
            fr.push_back(sub);
         end
         11: fr.push_back(8'($urandom_range(8'h12, 8'hFF)));
         default: fr.push_back(8'($urandom_range(0, 9)));
      endcase
      op  = fr[0];
      chk = 8'h00;
      foreach (fr[k]) chk ^= fr[k];
      if ($urandom_range(0, 9) == 0) chk = chk ^ 8'(1 << $urandom_range(0, 7));
      // unknown opcodes get no check byte of meaning; let noise follow anyway
      if (op_frame_len(op) != 0 || $urandom_range(0, 1) == 0) fr.push_back(chk);
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 3))
            fr.push_back(($urandom_range(0, 1) == 0) ? chk : 8'($urandom));
      end
      foreach (fr[k]) send_item(1'b0, k == 0, fr[k]);
      n_reads = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 70) : $urandom_range(0, 20);
      repeat (n_reads) send_item(1'b1, 1'($urandom_range(0, 1)), 8'($urandom));
   endtask

   // ------------------------------------------------------------------
   // Directed rows
   // ------------------------------------------------------------------
   typedef struct {
      bit         rd;
      bit         first;
      logic [7:0] b;
      bit         typed;
      logic [7:0] data;
      bit         from_answer;
   } row_type;

   row_type rows [$];

   function automatic void wr_row(bit first, logic [7:0] b);
      row_type r;
      r = '{1'b0, first, b, 1'b0, 8'h00, 1'b0};
      rows.push_back(r);
   endfunction

   function automatic void rd_row(logic [7:0] data, bit from_answer);
      row_type r;
      r = '{1'b1, 1'b0, 8'h00, 1'b1, data, from_answer};
      rows.push_back(r);
   endfunction

   initial begin
      read_byte_type tv;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tuser  = 2'b00;
      rsp_tready = 1'b0;
      csr_we     = 1'b0;
      csr_addr   = '0;
      csr_wdata  = 32'h0;
      cur_typed  = 1'b0;
      cur_typed_val = '0;
      quiet       = 1'b0;
      fail_count  = 0;
      items_sent  = 0;
      idle_cycles = 0;

      cfg_start = 32'd4000;
      cfg_end   = 32'd4500;
      cfg_every = 8'd0;
      foreach (rx_frame[k]) rx_frame[k] = 8'h00;
      rx_xor = 8'h00; rx_pos = 0; frame_len = 0;
      clock_time = 64'h0;
      intervals[0] = 32'd100; intervals[1] = 32'd1000; intervals[2] = 32'd10042;
      blk_left = 32'h0; blk_asked = 32'h0; blk_bytes = 16'h0; answers_built = 16'h0;
      pend_kind = i2c_cr_pkg::KIND_NONE; pend_pos = 0; pend_left = 0; pend_check = 8'h00;
      foreach (snap[k]) snap[k] = 32'h0;

      repeat (8) @(negedge clock);
      reset = 1'b0;

      // defaults written back so the typed rows hold
      csr_write(i2c_cr_pkg::CSR_DATA_START, 32'd4000);
      csr_write(i2c_cr_pkg::CSR_DATA_END, 32'd4500);
      csr_write(i2c_cr_pkg::CSR_CRC_EVERY, 32'd0);

      rd_row(i2c_cr_pkg::FILLER_BYTE, 1'b0);         // nothing pending after reset
      wr_row(1'b1, UNKNOWN_OP);                      // unknown opcode: error frame
      rd_row(8'hFF, 1'b1); rd_row(8'h00, 1'b1); rd_row(8'hFF, 1'b1);
      rd_row(i2c_cr_pkg::FILLER_BYTE, 1'b0);
      wr_row(1'b1, i2c_cr_pkg::OP_NOP); wr_row(1'b0, 8'h00);     // checksum mismatch
      rd_row(8'hFF, 1'b1); rd_row(8'h01, 1'b1); rd_row(8'hFE, 1'b1);
      wr_row(1'b1, i2c_cr_pkg::OP_DATA); wr_row(1'b0, i2c_cr_pkg::SUB_STOP);
      wr_row(1'b0, 8'h12);
      rd_row(8'h11, 1'b1); rd_row(8'h03, 1'b1); rd_row(8'h12, 1'b1);
      wr_row(1'b1, i2c_cr_pkg::OP_STATUS); wr_row(1'b0, 8'h07); wr_row(1'b0, 8'h0D);  // bad type
      rd_row(8'h0A, 1'b1); rd_row(8'hFF, 1'b1); rd_row(8'hF5, 1'b1);

      foreach (rows[k]) begin
         tv.data        = rows[k].data;
         tv.from_answer = rows[k].from_answer;
         send_item(rows[k].rd, rows[k].first, rows[k].b, rows[k].typed, tv);
      end
      drain();

      // random phases, register settings changed only while idle
      for (int phase = 0; items_sent < ITEM_TARGET; phase++) begin
         if (phase > 0) begin
            drain();
            set_area(phase);
         end
         repeat (60) begin
            if (items_sent < ITEM_TARGET) begin
               if ($urandom_range(0, 15) == 0)
                  send_item(1'($urandom_range(0, 1)), 1'b0, 8'($urandom));   // stray noise
               else
                  send_command();
            end
         end
      end

      drain();
      if (fail_count == 0) begin
         $display("** i2c_command_responder_core: PASSED **");
      end else begin
         $display("** i2c_command_responder_core: FAILED **");
      end
      $finish;
   end

endmodule
